// ===== hdl/melg_pkg.sv =====
`timescale 1ns / 1ps

package melg_pkg;

    // Word and field widths
    localparam int DATA_W      = 64;
    localparam int LOAD_ADDR_W = 10;

    // Ring size default
    localparam int RING_WORDS_DEF = 695;

    // Fixed read offsets ahead of the current word
    localparam int AHEAD_NEXT   = 1;
    localparam int AHEAD_MIX    = 373;
    localparam int AHEAD_TEMPER = 95;

    // Shift amounts of the lag, fresh and tempering steps
    localparam int LAG_SHIFT   = 37;
    localparam int FRESH_SHIFT = 14;
    localparam int OUT_SHIFT   = 6;

    // Masks
    localparam logic [DATA_W-1:0] UPPER_MASK  = 64'hffff_8000_0000_0000;
    localparam logic [DATA_W-1:0] LOWER_MASK  = 64'h0000_7fff_ffff_ffff;
    localparam logic [DATA_W-1:0] TEMPER_MASK = 64'h06fb_bee2_9aae_fd91;

    // Item opcodes
    typedef enum logic {
        OP_GENERATE = 1'b0,
        OP_LOAD     = 1'b1
    } t_op;

    // Ring read ports, one memory copy each
    localparam int NUM_PORTS = 4;
    localparam int P_CUR     = 0;
    localparam int P_NXT     = 1;
    localparam int P_MIX     = 2;
    localparam int P_TMP     = 3;

endpackage

// ===== hdl/melg_64bit_random_generator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                   Payload
// in        input      i_in_valid / o_in_ready     i_op, i_load_address, i_load_value
// out       output     o_out_valid / i_out_ready   o_random_value
// cfg       input      i_cfg_we (no wait)          i_cfg_data (matrix word)
//
// One item per cycle unless a held result stalls the input. Item steps: ring read
// in the accept cycle, mix/lag/temper in the next, then the output register.
// The ring lives in four copies of one synchronous RAM, one per fixed read offset;
// a write-back in the same cycle as a read of that word is forwarded.
// Reset clears position, pipeline valids and the matrix word; ring and lag word
// hold garbage until loaded. A held result stalls the input only once the
// compute stage also holds a generate item.

module melg_64bit_random_generator #(
    parameter int RING_WORDS = melg_pkg::RING_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [melg_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_op,
    input  logic [melg_pkg::LOAD_ADDR_W-1:0]  i_load_address,
    input  logic [melg_pkg::DATA_W-1:0]       i_load_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [melg_pkg::DATA_W-1:0]       o_random_value
);
    import melg_pkg::*;

    localparam int A_W = $clog2(RING_WORDS);

    // Modular add on ring positions, sum stays below twice the ring size
    function automatic logic [A_W-1:0] ring_add(input logic [A_W-1:0] base,
                                                input logic [A_W-1:0] off);
        logic [A_W:0] sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= (A_W+1)'(RING_WORDS)) begin
            sum = sum - (A_W+1)'(RING_WORDS);
        end
        return sum[A_W-1:0];
    endfunction

    // Control and state registers
    logic [DATA_W-1:0]     r_matrix;
    logic [DATA_W-1:0]     r_lag;
    logic [A_W-1:0]        r_pos;
    logic                  r_s1_valid;
    logic                  r_s1_load;
    logic                  r_s1_ring_we;
    logic                  r_s1_lag_we;
    logic [A_W-1:0]        r_s1_addr;
    logic [DATA_W-1:0]     r_s1_value;
    logic [NUM_PORTS-1:0]  r_fwd;
    logic [DATA_W-1:0]     r_fwd_data;
    logic                  r_out_valid;
    logic [DATA_W-1:0]     r_out_data;

    logic                  s1_go;
    logic                  s1_fire;
    logic                  accept;
    logic                  ring_we;
    logic [A_W-1:0]        n_pos;
    logic [NUM_PORTS-1:0]  n_fwd;
    logic [A_W-1:0]        rd_addr [NUM_PORTS];
    logic [DATA_W-1:0]     mem_q   [NUM_PORTS];
    logic [DATA_W-1:0]     word    [NUM_PORTS];
    logic [DATA_W-1:0]     mixed;
    logic [DATA_W-1:0]     lag_n;
    logic [DATA_W-1:0]     fresh;
    logic [DATA_W-1:0]     tempered;
    logic [DATA_W-1:0]     wr_data;

    // Handshake: compute stage moves on unless its result has nowhere to go
    assign s1_go      = !r_s1_valid || r_s1_load || !r_out_valid || i_out_ready;
    assign s1_fire    = r_s1_valid && s1_go;
    assign o_in_ready = s1_go && i_rst_n;
    assign accept     = i_in_valid && o_in_ready;
    assign ring_we    = s1_fire && r_s1_ring_we;

    // Read addresses from the current position
    always_comb begin
        rd_addr[P_CUR] = r_pos;
        rd_addr[P_NXT] = ring_add(r_pos, A_W'(AHEAD_NEXT));
        rd_addr[P_MIX] = ring_add(r_pos, A_W'(AHEAD_MIX));
        rd_addr[P_TMP] = ring_add(r_pos, A_W'(AHEAD_TEMPER));
    end

    // Forward a same-cycle write-back of the word being read
    always_comb begin
        for (int p = 0; p < NUM_PORTS; p++) begin
            n_fwd[p] = ring_we && (rd_addr[p] == r_s1_addr);
        end
    end

    // Next position: load rewinds, generate steps by one
    always_comb begin
        n_pos = r_pos;
        if (accept) begin
            if (i_op == OP_LOAD) begin
                n_pos = '0;
            end else begin
                n_pos = rd_addr[P_NXT];
            end
        end
    end

    // Ring copies, all written alike, each read at its own offset
    for (genvar p = 0; p < NUM_PORTS; p++) begin : g_copy
        logic [DATA_W-1:0] r_mem [RING_WORDS];
        logic [DATA_W-1:0] r_rd;

        always_ff @(posedge i_clk) begin
            if (ring_we) begin
                r_mem[r_s1_addr] <= wr_data;
            end
            if (accept) begin
                r_rd <= r_mem[rd_addr[p]];
            end
        end

        assign mem_q[p] = r_rd;
    end

    // Compute stage: mix, lag update, fresh word, tempering
    always_comb begin
        for (int p = 0; p < NUM_PORTS; p++) begin
            word[p] = r_fwd[p] ? r_fwd_data : mem_q[p];
        end
        mixed    = (word[P_CUR] & UPPER_MASK) | (word[P_NXT] & LOWER_MASK);
        lag_n    = (mixed >> 1) ^ (mixed[0] ? r_matrix : '0)
                 ^ word[P_MIX] ^ r_lag ^ (r_lag << LAG_SHIFT);
        fresh    = mixed ^ lag_n ^ (lag_n >> FRESH_SHIFT);
        tempered = fresh ^ (fresh << OUT_SHIFT) ^ (word[P_TMP] & TEMPER_MASK);
        wr_data  = r_s1_load ? r_s1_value : fresh;
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_matrix    <= '0;
            r_pos       <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_matrix <= i_cfg_data;
            end
            r_pos <= n_pos;
            if (s1_go) begin
                r_s1_valid <= accept;
            end
            if (s1_fire && !r_s1_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_load    <= (i_op == OP_LOAD);
            r_s1_ring_we <= (i_op == OP_GENERATE)
                         || (i_load_address < LOAD_ADDR_W'(RING_WORDS));
            r_s1_lag_we  <= (i_op == OP_GENERATE)
                         || (i_load_address == LOAD_ADDR_W'(RING_WORDS));
            r_s1_addr    <= (i_op == OP_LOAD) ? A_W'(i_load_address) : r_pos;
            r_s1_value   <= i_load_value;
            r_fwd        <= n_fwd;
            r_fwd_data   <= wr_data;
        end
        if (s1_fire && r_s1_lag_we) begin
            r_lag <= r_s1_load ? r_s1_value : lag_n;
        end
        if (s1_fire && !r_s1_load) begin
            r_out_data <= tempered;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_random_value = r_out_data;

    // Checks
    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos < A_W'(RING_WORDS))
        else $error("ring position out of range");

    a_load_rewinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_LOAD) |=> (r_pos == '0))
        else $error("load item did not rewind position");

    a_gen_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_op == OP_GENERATE && r_pos != A_W'(RING_WORDS - 1))
        |=> (r_pos == $past(r_pos) + A_W'(1)))
        else $error("generate item did not advance position");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && r_s1_load && (!r_out_valid || i_out_ready)) |=> !o_out_valid)
        else $error("load item produced a result");

endmodule

// ===== dv/melg_output_checker.sv =====
`timescale 1ns / 1ps

// Watches the input, output and matrix-word ports of the MELG-44497 generator,
// keeps its own copy of the ring, lag word and position, and checks every
// accepted random word in order against the predicted one.
module melg_output_checker #(
    parameter int RING_WORDS = melg_pkg::RING_WORDS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [melg_pkg::DATA_W-1:0]       i_cfg_data,
    input  logic                              i_in_valid,
    input  logic                              i_in_ready,
    input  melg_pkg::t_op                     i_op,
    input  logic [melg_pkg::LOAD_ADDR_W-1:0]  i_load_address,
    input  logic [melg_pkg::DATA_W-1:0]       i_load_value,
    input  logic                              i_out_valid,
    input  logic                              i_out_ready,
    input  logic [melg_pkg::DATA_W-1:0]       i_random_value,
    output int                                o_error_count,
    output int                                o_pending
);
    import melg_pkg::*;

    // Predicted generator state
    logic [DATA_W-1:0] ring_copy [RING_WORDS];
    logic [DATA_W-1:0] lag_copy;
    logic [DATA_W-1:0] matrix_copy;
    int unsigned       word_pos;

    // Random words predicted but not yet seen on the output
    logic [DATA_W-1:0] expected_words [$];

    initial begin
        o_error_count = 0;
        o_pending     = 0;
    end

    task automatic report_mismatch(input string what);
        begin
            $display("[%0t] MISMATCH: %s", $realtime, what);
            o_error_count = o_error_count + 1;
        end
    endtask

    // One generator step: advance the position, update lag and ring, temper
    function logic [DATA_W-1:0] next_random_word();
        int unsigned       cur;
        int unsigned       nxt;
        logic [DATA_W-1:0] mixed;
        logic [DATA_W-1:0] lag;
        logic [DATA_W-1:0] fresh;
        begin
            cur      = word_pos;
            nxt      = (cur + AHEAD_NEXT) % RING_WORDS;
            word_pos = nxt;

            mixed = (ring_copy[cur] & UPPER_MASK) | (ring_copy[nxt] & LOWER_MASK);
            lag   = lag_copy;
            lag   = (mixed >> 1) ^ (mixed[0] ? matrix_copy : '0)
                  ^ ring_copy[(cur + AHEAD_MIX) % RING_WORDS]
                  ^ lag ^ (lag << LAG_SHIFT);
            lag_copy = lag;

            fresh          = mixed ^ lag ^ (lag >> FRESH_SHIFT);
            ring_copy[cur] = fresh;

            next_random_word = fresh ^ (fresh << OUT_SHIFT)
                ^ (ring_copy[(cur + AHEAD_TEMPER) % RING_WORDS] & TEMPER_MASK);
        end
    endfunction

    // Sample all channels at the rising edge
    always @(posedge i_clk) begin
        logic [DATA_W-1:0] want;
        if (!i_rst_n) begin
            word_pos    = 0;
            matrix_copy = '0;
            lag_copy    = '0;
            expected_words.delete();
        end else begin
            if (i_cfg_we)
                matrix_copy = i_cfg_data;

            // Accepted input item
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_LOAD) begin
                    if (i_load_address < RING_WORDS)
                        ring_copy[i_load_address] = i_load_value;
                    else if (i_load_address == RING_WORDS)
                        lag_copy = i_load_value;
                    word_pos = 0;
                end else begin
                    expected_words.push_back(next_random_word());
                end
            end

            // Accepted result item
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    report_mismatch($sformatf("unexpected random_value %h", i_random_value));
                end else begin
                    want = expected_words.pop_front();
                    if (i_random_value !== want)
                        report_mismatch($sformatf("random_value %h, expected %h",
                                                  i_random_value, want));
                end
            end
        end
        o_pending <= expected_words.size();
    end

endmodule

// ===== dv/melg_64bit_random_generator_test.sv =====
`timescale 1ns / 1ps

module melg_64bit_random_generator_test;
    import melg_pkg::*;

    localparam int RING_WORDS  = RING_WORDS_DEF;
    localparam int ADDR_MAX    = (1 << LOAD_ADDR_W) - 1;
    localparam int IDLE_SLACK  = 8;
    localparam int WRAP_RUN    = 720;
    localparam int PHASE_ITEMS = 200;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [DATA_W-1:0]      cfg_data;
    logic                   in_valid;
    logic                   in_ready;
    t_op                    in_op;
    logic [LOAD_ADDR_W-1:0] load_address;
    logic [DATA_W-1:0]      load_value;
    logic                   out_valid;
    logic                   out_ready = 1'b1;
    logic [DATA_W-1:0]      random_value;

    int error_count;
    int pending;
    int burst_left;

    logic [15:0] stall_pattern = '1;
    logic [5:0]  stall_count   = '0;

    always #2 clk = ~clk;

    melg_64bit_random_generator DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .o_in_ready     (in_ready),
        .i_op           (in_op),
        .i_load_address (load_address),
        .i_load_value   (load_value),
        .o_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .o_random_value (random_value)
    );

    melg_output_checker #(
        .RING_WORDS (RING_WORDS)
    ) output_check (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_op           (in_op),
        .i_load_address (load_address),
        .i_load_value   (load_value),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_random_value (random_value),
        .o_error_count  (error_count),
        .o_pending      (pending)
    );

    // Receiver stalls: a rotating 16-bit pattern, reloaded when the 6-bit counter wraps,
    // sometimes all ones for stall-free stretches
    always @(negedge clk) begin
        stall_count <= stall_count + 1'b1;
        if (stall_count == 0) begin
            stall_pattern <= ($urandom_range(0, 2) == 0) ? '1 : 16'($urandom);
        end else begin
            stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
        end
        out_ready <= stall_pattern[0];
    end

    // 64-bit value with a bias toward the extremes
    function automatic logic [DATA_W-1:0] rand_word();
        int pick;
        begin
            pick = $urandom_range(0, 15);
            if (pick == 0)
                rand_word = '0;
            else if (pick == 1)
                rand_word = '1;
            else
                rand_word = {$urandom, $urandom};
        end
    endfunction

    // Present one item from a falling edge and hold it until accepted;
    // bursts of random length with random gaps in between
    task automatic send_item(input t_op op, input logic [LOAD_ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] value);
        int gap;
        begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 32);
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                if (gap != 0) begin
                    in_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            in_valid     <= 1'b1;
            in_op        <= op;
            load_address <= addr;
            load_value   <= value;
            do @(posedge clk); while (!in_ready);
            @(negedge clk);
            burst_left = burst_left - 1;
        end
    endtask

    // Hold off until every predicted word has come out, then let loads settle
    task automatic wait_idle();
        begin
            in_valid <= 1'b0;
            do @(negedge clk); while (pending != 0);
            repeat (IDLE_SLACK) @(negedge clk);
        end
    endtask

    // Matrix word write, only while the block is idle
    task automatic write_matrix(input logic [DATA_W-1:0] value);
        begin
            cfg_we   <= 1'b1;
            cfg_data <= value;
            @(negedge clk);
            cfg_we   <= 1'b0;
        end
    endtask

    // Mostly generate runs, with loads that land on the words read right
    // after the position returns to 0, random loads up to the lag word, and loads past it
    task automatic run_random_traffic(input int item_count);
        int sent;
        int run_len;
        int pick;
        logic [LOAD_ADDR_W-1:0] addr;
        begin
            sent = 0;
            while (sent < item_count) begin
                pick = $urandom_range(0, 99);
                if (pick == 0) begin
                    wait_idle();
                end else if (pick < 80) begin
                    run_len = $urandom_range(1, 40);
                    repeat (run_len) send_item(OP_GENERATE, LOAD_ADDR_W'($urandom), rand_word());
                    sent = sent + run_len;
                end else begin
                    if (pick < 88) begin
                        case ($urandom_range(0, 7))
                            0: addr = '0;
                            1: addr = LOAD_ADDR_W'(AHEAD_NEXT);
                            2: addr = LOAD_ADDR_W'(AHEAD_TEMPER);
                            3: addr = LOAD_ADDR_W'(AHEAD_TEMPER + 1);
                            4: addr = LOAD_ADDR_W'(AHEAD_MIX);
                            5: addr = LOAD_ADDR_W'(AHEAD_MIX + 1);
                            6: addr = LOAD_ADDR_W'(RING_WORDS - 1);
                            default: addr = LOAD_ADDR_W'(RING_WORDS);
                        endcase
                    end else if (pick < 95) begin
                        addr = LOAD_ADDR_W'($urandom_range(0, RING_WORDS));
                    end else begin
                        addr = LOAD_ADDR_W'($urandom_range(RING_WORDS + 1, ADDR_MAX));
                    end
                    send_item(OP_LOAD, addr, rand_word());
                    sent = sent + 1;
                end
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_op        = OP_GENERATE;
        load_address = '0;
        load_value   = '0;
        burst_left   = 0;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Matrix at all ones, then fill ring and lag word in address order
        write_matrix('1);
        for (int a = 0; a <= RING_WORDS; a++)
            send_item(OP_LOAD, LOAD_ADDR_W'(a), rand_word());

        // Directed: ignored load fields, load past the lag word, lag extremes,
        // load then generate reading the just-loaded words
        send_item(OP_GENERATE, LOAD_ADDR_W'(ADDR_MAX), '1);
        send_item(OP_GENERATE, '0, '0);
        send_item(OP_GENERATE, LOAD_ADDR_W'(RING_WORDS), '1);
        send_item(OP_LOAD, LOAD_ADDR_W'(ADDR_MAX), '1);
        send_item(OP_GENERATE, '0, '0);
        send_item(OP_GENERATE, '1, '1);
        send_item(OP_LOAD, LOAD_ADDR_W'(RING_WORDS), '0);
        send_item(OP_GENERATE, '0, '0);
        send_item(OP_LOAD, LOAD_ADDR_W'(RING_WORDS), '1);
        send_item(OP_GENERATE, '0, '0);
        send_item(OP_LOAD, '0, '1);
        send_item(OP_LOAD, LOAD_ADDR_W'(AHEAD_NEXT), '0);
        send_item(OP_GENERATE, '0, '0);
        send_item(OP_GENERATE, '0, '0);
        send_item(OP_LOAD, LOAD_ADDR_W'(RING_WORDS + 1), rand_word());
        send_item(OP_GENERATE, '0, '0);
        send_item(OP_LOAD, LOAD_ADDR_W'(RING_WORDS - 1), '1);
        send_item(OP_GENERATE, '0, '0);

        // Long generate run so the position wraps around the ring
        repeat (WRAP_RUN) send_item(OP_GENERATE, LOAD_ADDR_W'($urandom), rand_word());
        wait_idle();

        // Random phases under different matrix words
        write_matrix('0);
        run_random_traffic(PHASE_ITEMS);
        wait_idle();

        write_matrix({$urandom, $urandom});
        run_random_traffic(PHASE_ITEMS);
        wait_idle();

        write_matrix({1'b1, {(DATA_W - 2){1'b0}}, 1'b1});
        run_random_traffic(PHASE_ITEMS);
        wait_idle();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
